@@ sv/phd_pkg.sv @@
// phd_pkg: shared types and constants for the piezo pad hit detector.
// No dependencies; used by phd_div, phd_pad_mem and piezo_pad_hit_detector.
`default_nettype none
package phd_pkg;

  localparam int SAMPLE_W = 12;
  localparam int VEL_W    = 7;
  localparam int TIME_W   = 32;
  localparam int CFG_MS_W = 16;
  localparam int PAD_W    = 3;
  localparam int KIND_W   = 2;
  localparam int CFG_W    = 16;
  localparam int CFG_IDX_W = 2;
  // (sample - threshold) * 127 fits in 19 bits
  localparam int PROD_W   = SAMPLE_W + VEL_W;

  localparam logic [SAMPLE_W-1:0] ADC_FULL = 12'hFFF;
  localparam logic [VEL_W-1:0]    VEL_MIN  = 7'd1;

  localparam logic [KIND_W-1:0] KIND_NONE    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_HIT     = 2'd1;
  localparam logic [KIND_W-1:0] KIND_RELEASE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT   = 2'd2;

  localparam logic [SAMPLE_W-1:0] THRESHOLD_RST = 12'd50;
  localparam logic [CFG_MS_W-1:0] DEBOUNCE_RST  = 16'd10;
  localparam logic [CFG_MS_W-1:0] TIMEOUT_RST   = 16'd50;

  // per-pad state as held in the pad memory
  typedef struct packed {
    logic              active;
    logic [TIME_W-1:0] hit_time;
    logic [VEL_W-1:0]  vel;
  } pad_entry_t;

  localparam int ENTRY_W = 1 + TIME_W + VEL_W;

endpackage
`default_nettype wire

@@ sv/piezo_pad_hit_detector.sv @@
// piezo_pad_hit_detector: drum pad hit and release detector, top level.
// Depends on phd_pkg, phd_div and phd_pad_mem.
//
// Use:
//  - Input channel (in_valid/in_ready) takes one item: pad_index, a 12-bit
//    sample and a wrapping millisecond timestamp now_ms.
//  - Output channel (out_valid/out_ready) returns exactly one result item per
//    input item: event_pad, event_kind (none/hit/release), velocity, pad_active.
//  - Config port: cfg_we writes cfg_data into register cfg_index
//    (0 threshold, 1 debounce ms, 2 active timeout ms). Write only when idle.
// Timing:
//  - Items are handled one at a time. No hit: the item passes the read and
//    evaluate step and the finish step, and in_ready comes back with the
//    result. A hit passes through the bit-serial divider between the two (7
//    quotient bits, then an idle check) before the finish step.
//  - in_ready is high in the idle state; a result waiting in the output
//    register does not block the next item until its finish cycle, which then
//    holds until the receiver has taken the earlier result.
// Reset (rst, synchronous): registers return to 50 / 10 / 50, all pads read
// as inactive with zero hit time and velocity (per-entry valid bits), no
// clearing pass needed.
`default_nettype none
module piezo_pad_hit_detector #(
  parameter int NUM_PADS = 6
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // input items
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [phd_pkg::PAD_W-1:0]     pad_index,
  input  wire logic [phd_pkg::SAMPLE_W-1:0]  sample,
  input  wire logic [phd_pkg::TIME_W-1:0]    now_ms,
  // result items
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [phd_pkg::PAD_W-1:0]          event_pad,
  output logic [phd_pkg::KIND_W-1:0]         event_kind,
  output logic [phd_pkg::VEL_W-1:0]          velocity,
  output logic                               pad_active,
  // configuration writes
  input  wire logic                          cfg_we,
  input  wire logic [phd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [phd_pkg::CFG_W-1:0]     cfg_data
);

  localparam int AW    = (NUM_PADS > 1) ? $clog2(NUM_PADS) : 1;
  // one spare bit so that NUM_PADS itself fits for the range compare
  localparam int EXT_W = ((AW > phd_pkg::PAD_W) ? AW : phd_pkg::PAD_W) + 1;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_READ   = 2'd1;
  localparam logic [1:0] ST_DIV    = 2'd2;
  localparam logic [1:0] ST_FINISH = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  // configuration registers
  logic [phd_pkg::SAMPLE_W-1:0] hit_threshold;
  logic [phd_pkg::CFG_MS_W-1:0] debounce_ms;
  logic [phd_pkg::CFG_MS_W-1:0] active_timeout_ms;

  always_ff @(posedge clk) begin
    if (rst) begin
      hit_threshold     <= phd_pkg::THRESHOLD_RST;
      debounce_ms       <= phd_pkg::DEBOUNCE_RST;
      active_timeout_ms <= phd_pkg::TIMEOUT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        phd_pkg::REG_THRESHOLD: hit_threshold     <= cfg_data[phd_pkg::SAMPLE_W-1:0];
        phd_pkg::REG_DEBOUNCE:  debounce_ms       <= cfg_data[phd_pkg::CFG_MS_W-1:0];
        phd_pkg::REG_TIMEOUT:   active_timeout_ms <= cfg_data[phd_pkg::CFG_MS_W-1:0];
        default: ;
      endcase
    end
  end

  // latched item
  logic [phd_pkg::PAD_W-1:0]    pad_q;
  logic [phd_pkg::SAMPLE_W-1:0] sample_q;
  logic [phd_pkg::TIME_W-1:0]   now_q;
  logic                         accept;

  assign in_ready = state == ST_IDLE;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (accept) begin
      pad_q    <= pad_index;
      sample_q <= sample;
      now_q    <= now_ms;
    end
  end

  // pad store addressing
  logic [EXT_W-1:0] in_pad_ext;
  logic [EXT_W-1:0] pad_q_ext;
  logic [AW-1:0]    rd_addr;
  logic [AW-1:0]    wr_addr;

  assign in_pad_ext = EXT_W'(pad_index);
  assign pad_q_ext  = EXT_W'(pad_q);
  assign rd_addr    = in_pad_ext[AW-1:0];
  assign wr_addr    = pad_q_ext[AW-1:0];

  phd_pkg::pad_entry_t rd_entry;
  phd_pkg::pad_entry_t wr_entry;
  logic                wr_en;

  phd_pad_mem #(
    .NUM_PADS (NUM_PADS),
    .AW       (AW)
  ) u_mem (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (accept),
    .rd_addr (rd_addr),
    .rd_data (rd_entry),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_entry)
  );

  // evaluation in the read cycle
  logic                       in_range;
  logic [phd_pkg::TIME_W-1:0] elapsed;
  logic                       hit;
  logic [phd_pkg::SAMPLE_W-1:0] diff;
  logic [phd_pkg::PROD_W-1:0] dividend;
  logic [phd_pkg::SAMPLE_W-1:0] span;

  assign in_range = pad_q_ext < EXT_W'(NUM_PADS);
  assign elapsed  = now_q - rd_entry.hit_time;
  assign hit      = in_range && !rd_entry.active && (sample_q > hit_threshold) &&
                    (elapsed >= phd_pkg::TIME_W'(debounce_ms));
  assign diff     = sample_q - hit_threshold;
  // diff * 127 as diff * 128 - diff
  assign dividend = {diff, {phd_pkg::VEL_W{1'b0}}} - phd_pkg::PROD_W'(diff);
  assign span     = phd_pkg::ADC_FULL - hit_threshold;

  logic                       div_start;
  logic                       div_busy;
  logic [phd_pkg::VEL_W-1:0]  quotient;

  assign div_start = (state == ST_READ) && hit;

  phd_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (dividend),
    .divisor  (span),
    .busy     (div_busy),
    .quotient (quotient)
  );

  // values held from the read cycle to the finish cycle
  phd_pkg::pad_entry_t        entry_q;
  logic                       in_range_q;
  logic                       hit_q;
  logic [phd_pkg::TIME_W-1:0] elapsed_q;

  always_ff @(posedge clk) begin
    if (state == ST_READ) begin
      entry_q    <= rd_entry;
      in_range_q <= in_range;
      hit_q      <= hit;
      elapsed_q  <= elapsed;
    end
  end

  // finish: release check, store update, result
  logic                       release_now;
  logic [phd_pkg::VEL_W-1:0]  hit_vel;
  logic                       active_new;
  logic                       finish;
  logic [phd_pkg::KIND_W-1:0] kind_new;
  logic [phd_pkg::VEL_W-1:0]  vel_new;

  assign hit_vel = (quotient == '0) ? phd_pkg::VEL_MIN : quotient;
  // a fresh hit has zero elapsed time, so it releases only on a zero timeout
  assign release_now = hit_q ? (active_timeout_ms == '0) :
                       (entry_q.active && (elapsed_q >= phd_pkg::TIME_W'(active_timeout_ms)));
  assign active_new  = (entry_q.active || hit_q) && !release_now;
  assign finish      = (state == ST_FINISH) && !(out_valid && !out_ready);

  always_comb begin
    wr_entry = entry_q;
    if (hit_q) begin
      wr_entry.hit_time = now_q;
      wr_entry.vel      = hit_vel;
    end
    if (release_now) begin
      wr_entry.vel = '0;
    end
    wr_entry.active = active_new;

    if (!in_range_q) begin
      kind_new = phd_pkg::KIND_NONE;
      vel_new  = '0;
    end else if (hit_q) begin
      kind_new = phd_pkg::KIND_HIT;
      vel_new  = hit_vel;
    end else if (release_now) begin
      kind_new = phd_pkg::KIND_RELEASE;
      vel_new  = '0;
    end else begin
      kind_new = phd_pkg::KIND_NONE;
      vel_new  = entry_q.vel;
    end
  end

  assign wr_en = finish && in_range_q;

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      event_pad  <= pad_q;
      event_kind <= kind_new;
      velocity   <= vel_new;
      pad_active <= in_range_q && active_new;
    end
  end

  // sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (accept) state_next = ST_READ;
      ST_READ:   state_next = hit ? ST_DIV : ST_FINISH;
      ST_DIV:    if (!div_busy) state_next = ST_FINISH;
      ST_FINISH: if (finish) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // checks
  a_accept_reads: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == ST_READ)
    else $error("accepted item did not move to pad read");

  a_hit_has_vel: assert property (@(posedge clk) disable iff (rst)
    (out_valid && event_kind == phd_pkg::KIND_HIT) |-> velocity != '0)
    else $error("hit result with zero velocity");

  a_active_has_vel: assert property (@(posedge clk) disable iff (rst)
    (out_valid && pad_active) |-> velocity != '0)
    else $error("active pad reported with zero velocity");

  a_result_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ST_FINISH)
    else $error("result raised outside the finish step");

endmodule
`default_nettype wire

@@ sv/phd_div.sv @@
// phd_div: restoring divider, one quotient bit per cycle, 7-bit quotient.
// Depends on phd_pkg. Dividend must be below 128 * divisor.
`default_nettype none
module phd_div (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  input  wire logic [phd_pkg::PROD_W-1:0]   dividend,
  input  wire logic [phd_pkg::SAMPLE_W-1:0] divisor,
  output logic                              busy,
  output logic [phd_pkg::VEL_W-1:0]         quotient
);

  localparam int CNT_W = $clog2(phd_pkg::VEL_W + 1);

  logic [phd_pkg::PROD_W-1:0] rem;
  logic [phd_pkg::PROD_W-1:0] dsh;
  logic [CNT_W-1:0]           cnt;
  logic                       ge;

  assign ge   = rem >= dsh;
  assign busy = cnt != '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= CNT_W'(phd_pkg::VEL_W);
    end else if (busy) begin
      cnt <= cnt - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= dividend;
      // divisor aligned to the top quotient bit
      dsh      <= phd_pkg::PROD_W'(divisor) << (phd_pkg::VEL_W - 1);
      quotient <= '0;
    end else if (busy) begin
      if (ge) begin
        rem <= rem - dsh;
      end
      dsh      <= dsh >> 1;
      quotient <= {quotient[phd_pkg::VEL_W-2:0], ge};
    end
  end

endmodule
`default_nettype wire

@@ sv/phd_pad_mem.sv @@
// phd_pad_mem: per-pad state store, one write and one registered read port.
// Depends on phd_pkg. Entries never written read as all zero via valid bits.
`default_nettype none
module phd_pad_mem #(
  parameter int NUM_PADS = 6,
  parameter int AW       = 3
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                rd_en,
  input  wire logic [AW-1:0]       rd_addr,
  output phd_pkg::pad_entry_t      rd_data,
  input  wire logic                wr_en,
  input  wire logic [AW-1:0]       wr_addr,
  input  wire phd_pkg::pad_entry_t wr_data
);

  phd_pkg::pad_entry_t mem [NUM_PADS];
  logic [NUM_PADS-1:0] valid;
  phd_pkg::pad_entry_t rd_q;
  logic                rd_valid;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (wr_en) begin
        valid[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_valid <= valid[rd_addr];
      end
    end
  end

  assign rd_data = rd_valid ? rd_q : '0;

endmodule
`default_nettype wire
